[rtl/core/fba_pkg.sv]
// Shared types and constants for the frame bitmap allocator.
// Used by the register block, controller, datapath and top level.
package fba_pkg;

	localparam int BITMAP_WORDS_DEF = 1024;
	localparam int FRAME_SHIFT_DEF  = 12;

	localparam int WORD_BITS  = 32;
	localparam int BIT_W      = 5;
	localparam int COUNT_W    = 16;
	localparam int LIMIT_W    = 17;
	localparam int ADDR_OUT_W = 27;
	localparam int PADDR_W    = 3;
	localparam int PDATA_W    = 32;

	localparam logic [1:0] OP_MARK    = 2'd0;
	localparam logic [1:0] OP_RELEASE = 2'd1;
	localparam logic [1:0] OP_TEST    = 2'd2;
	localparam logic [1:0] OP_FIND    = 2'd3;

	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_RANGE = 2'd1;
	localparam logic [1:0] ST_NONE  = 2'd2;

	localparam logic REG_FRAME_COUNT = 1'b0;

	typedef enum logic [2:0] {
		S_CLEAR,
		S_IDLE,
		S_RMW,
		S_FIND,
		S_RESP
	} fba_state_t;

	// controller to datapath
	typedef struct packed {
		logic clr_wr;
		logic load_item;
		logic rmw_finish;
		logic scan_step;
		logic res_hit;
		logic res_none;
		logic out_from_res;
	} fba_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic clr_last;
		logic scan_hit;
		logic scan_idle;
	} fba_sts_t;

endpackage

[rtl/core/fba_regs.sv]
// Configuration register block: APB-style slave holding frame_count.
// Depends on fba_pkg; produces the capped count of bitmap words in use.
module fba_regs #(
	parameter int BITMAP_WORDS = fba_pkg::BITMAP_WORDS_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [fba_pkg::PADDR_W-1:0]  paddr,
	input  logic [fba_pkg::PDATA_W-1:0]  pwdata,
	output logic [fba_pkg::PDATA_W-1:0]  prdata,
	output logic                         pready,
	output logic [fba_pkg::LIMIT_W-1:0]  limit
);

	logic [fba_pkg::COUNT_W-1:0] frame_count_q;
	logic [fba_pkg::LIMIT_W-1:0] whole_words;
	logic                        sel_count;

	assign sel_count = (paddr[2] == fba_pkg::REG_FRAME_COUNT);
	assign pready    = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_count_q <= '0;
		end else if (psel && penable && pwrite && sel_count) begin
			frame_count_q <= pwdata[fba_pkg::COUNT_W-1:0];
		end
	end

	always_comb begin
		prdata = '0;
		if (sel_count) begin
			prdata = fba_pkg::PDATA_W'(frame_count_q);
		end
	end

	// only whole 32-frame words count, capped at the bitmap size
	assign whole_words = fba_pkg::LIMIT_W'(frame_count_q[fba_pkg::COUNT_W-1:fba_pkg::BIT_W]);
	assign limit = (whole_words > fba_pkg::LIMIT_W'(BITMAP_WORDS)) ?
		fba_pkg::LIMIT_W'(BITMAP_WORDS) : whole_words;

endmodule

[rtl/core/fba_dp.sv]
// Datapath: bitmap memory, item registers, word scanner and result registers.
// Depends on fba_pkg; driven by fba_ctrl through fba_cmd_t.
module fba_dp #(
	parameter int BITMAP_WORDS = fba_pkg::BITMAP_WORDS_DEF,
	parameter int FRAME_SHIFT  = fba_pkg::FRAME_SHIFT_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  fba_pkg::fba_cmd_t              cmd,
	output fba_pkg::fba_sts_t              sts,
	input  logic [fba_pkg::LIMIT_W-1:0]    limit,
	input  logic [1:0]                     op,
	input  logic [31:0]                    byte_address,
	output logic                           frame_used,
	output logic [fba_pkg::ADDR_OUT_W-1:0] free_address,
	output logic [1:0]                     status
);

	localparam int AW     = (BITMAP_WORDS > 1) ? $clog2(BITMAP_WORDS) : 1;
	localparam int CNT_W  = $clog2(BITMAP_WORDS + 1);
	localparam int WIDX_W = 32 - FRAME_SHIFT - fba_pkg::BIT_W;
	localparam int EXT_W  = fba_pkg::ADDR_OUT_W + AW + fba_pkg::BIT_W + FRAME_SHIFT;

	logic [fba_pkg::WORD_BITS-1:0] bitmap_mem [BITMAP_WORDS];
	logic [fba_pkg::WORD_BITS-1:0] rd_data_q;

	logic [1:0]              op_q;
	logic [AW-1:0]           widx_q;
	logic [fba_pkg::BIT_W-1:0] bit_q;
	logic                    range_q;

	logic [CNT_W-1:0]        rd_idx_q;
	logic                    v_s1;
	logic [AW-1:0]           idx_s1;

	logic [fba_pkg::ADDR_OUT_W-1:0] res_addr_q;
	logic [1:0]                     res_status_q;

	logic [fba_pkg::ADDR_OUT_W-1:0] out_addr_q;
	logic [1:0]                     out_status_q;
	logic                           out_used_q;

	logic [WIDX_W-1:0]       in_widx;
	logic                    in_range;
	logic                    issue;
	logic                    rd_en;
	logic [31:0]             rd_addr_ext;
	logic                    wr_en;
	logic [AW-1:0]           wr_addr;
	logic [fba_pkg::WORD_BITS-1:0] wr_data;
	logic [fba_pkg::WORD_BITS-1:0] bit_mask;
	logic [fba_pkg::BIT_W-1:0] zero_pos;
	logic [EXT_W-1:0]        found_ext;
	logic                    rmw_used;
	logic [1:0]              rmw_status;

	assign in_widx  = byte_address[31:FRAME_SHIFT+fba_pkg::BIT_W];
	assign in_range = (32'(in_widx) < 32'(limit));
	assign issue    = (32'(rd_idx_q) < 32'(limit));

	assign rd_en   = cmd.load_item || (cmd.scan_step && issue);

	assign rd_addr_ext = cmd.load_item ? 32'(in_widx) : 32'(rd_idx_q[AW-1:0]);

	assign bit_mask = fba_pkg::WORD_BITS'(1) << bit_q;
	assign wr_en    = cmd.clr_wr ||
		(cmd.rmw_finish && range_q && (op_q == fba_pkg::OP_MARK || op_q == fba_pkg::OP_RELEASE));
	assign wr_addr  = cmd.clr_wr ? rd_idx_q[AW-1:0] : widx_q;

	always_comb begin
		wr_data = '0;
		if (!cmd.clr_wr) begin
			if (op_q == fba_pkg::OP_MARK) begin
				wr_data = rd_data_q | bit_mask;
			end else begin
				wr_data = rd_data_q & ~bit_mask;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			bitmap_mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= bitmap_mem[rd_addr_ext[AW-1:0]];
		end
	end

	// lowest clear bit of the word under check
	always_comb begin
		zero_pos = '0;
		for (int k = fba_pkg::WORD_BITS - 1; k >= 0; k--) begin
			if (!rd_data_q[k]) begin
				zero_pos = fba_pkg::BIT_W'(k);
			end
		end
	end

	assign found_ext = EXT_W'({idx_s1, zero_pos, {FRAME_SHIFT{1'b0}}});

	assign sts.clr_last  = (32'(rd_idx_q[AW-1:0]) == 32'(BITMAP_WORDS - 1));
	assign sts.scan_hit  = v_s1 && (rd_data_q != '1);
	assign sts.scan_idle = !v_s1 && !issue;

	// scan counter doubles as the clearing-pass address
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_idx_q <= '0;
			v_s1     <= 1'b0;
		end else if (cmd.load_item) begin
			rd_idx_q <= '0;
			v_s1     <= 1'b0;
		end else if (cmd.clr_wr) begin
			rd_idx_q <= rd_idx_q + CNT_W'(1);
		end else if (cmd.scan_step) begin
			v_s1 <= issue;
			if (issue) begin
				rd_idx_q <= rd_idx_q + CNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.scan_step) begin
			idx_s1 <= rd_idx_q[AW-1:0];
		end
		if (cmd.load_item) begin
			op_q    <= op;
			widx_q  <= rd_addr_ext[AW-1:0];
			bit_q   <= byte_address[FRAME_SHIFT+fba_pkg::BIT_W-1:FRAME_SHIFT];
			range_q <= in_range;
		end
		if (cmd.res_hit) begin
			res_addr_q   <= found_ext[fba_pkg::ADDR_OUT_W-1:0];
			res_status_q <= fba_pkg::ST_OK;
		end else if (cmd.res_none) begin
			res_addr_q   <= '0;
			res_status_q <= fba_pkg::ST_NONE;
		end
	end

	assign rmw_used   = (op_q == fba_pkg::OP_TEST) && range_q && rd_data_q[bit_q];
	assign rmw_status = range_q ? fba_pkg::ST_OK : fba_pkg::ST_RANGE;

	always_ff @(posedge clk) begin
		if (cmd.rmw_finish) begin
			out_used_q   <= rmw_used;
			out_addr_q   <= '0;
			out_status_q <= rmw_status;
		end else if (cmd.out_from_res) begin
			out_used_q   <= 1'b0;
			out_addr_q   <= res_addr_q;
			out_status_q <= res_status_q;
		end
	end

	assign frame_used   = out_used_q;
	assign free_address = out_addr_q;
	assign status       = out_status_q;

endmodule

[rtl/core/fba_ctrl.sv]
// Controller: sequences clearing, item accept, read-modify-write and scan.
// Depends on fba_pkg; commands fba_dp and owns the output valid flag.
module fba_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	input  logic [1:0]        op,
	output logic              out_valid,
	input  logic              out_stall,
	input  fba_pkg::fba_sts_t sts,
	output fba_pkg::fba_cmd_t cmd
);

	fba_pkg::fba_state_t state_q;
	fba_pkg::fba_state_t state_d;
	logic                out_valid_q;
	logic                slot_free;

	assign slot_free = !out_valid_q || !out_stall;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			fba_pkg::S_CLEAR: begin
				if (sts.clr_last) begin
					state_d = fba_pkg::S_IDLE;
				end
			end
			fba_pkg::S_IDLE: begin
				if (in_valid) begin
					state_d = (op == fba_pkg::OP_FIND) ? fba_pkg::S_FIND : fba_pkg::S_RMW;
				end
			end
			fba_pkg::S_RMW: begin
				if (slot_free) begin
					state_d = fba_pkg::S_IDLE;
				end
			end
			fba_pkg::S_FIND: begin
				if (sts.scan_hit || sts.scan_idle) begin
					state_d = fba_pkg::S_RESP;
				end
			end
			fba_pkg::S_RESP: begin
				if (slot_free) begin
					state_d = fba_pkg::S_IDLE;
				end
			end
			default: state_d = fba_pkg::S_IDLE;
		endcase
	end

	always_comb begin
		cmd      = '0;
		in_stall = 1'b1;
		unique case (state_q)
			fba_pkg::S_CLEAR: begin
				cmd.clr_wr = 1'b1;
			end
			fba_pkg::S_IDLE: begin
				in_stall      = 1'b0;
				cmd.load_item = in_valid;
			end
			fba_pkg::S_RMW: begin
				cmd.rmw_finish = slot_free;
			end
			fba_pkg::S_FIND: begin
				cmd.scan_step = 1'b1;
				cmd.res_hit   = sts.scan_hit;
				cmd.res_none  = !sts.scan_hit && sts.scan_idle;
			end
			fba_pkg::S_RESP: begin
				cmd.out_from_res = slot_free;
			end
			default: begin
				cmd = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= fba_pkg::S_CLEAR;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.rmw_finish || cmd.out_from_res) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid = out_valid_q;

endmodule

[rtl/core/frame_bitmap_allocator.sv]
// Frame bitmap allocator: one used bit per (1 << FRAME_SHIFT)-byte frame, kept
// in BITMAP_WORDS 32-bit words of a single-port-style memory. After reset a
// clearing pass zeroes the memory, one word a cycle, during which no item is
// accepted (configuration writes still go through). Mark, release and test have
// an accept step that reads the word and a step that writes it back and loads
// the result. Find reads one word per cycle starting at word 0 until the first
// word with a clear bit, or through all W words in use when they are all full.
// Either result is loaded only once the output register is free or not stalled.
// One item is in work at a time; the output register lets the next item be
// accepted while a result waits.
module frame_bitmap_allocator #(
	parameter int BITMAP_WORDS = fba_pkg::BITMAP_WORDS_DEF,
	parameter int FRAME_SHIFT  = fba_pkg::FRAME_SHIFT_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           psel,
	input  logic                           penable,
	input  logic                           pwrite,
	input  logic [fba_pkg::PADDR_W-1:0]    paddr,
	input  logic [fba_pkg::PDATA_W-1:0]    pwdata,
	output logic [fba_pkg::PDATA_W-1:0]    prdata,
	output logic                           pready,
	input  logic                           in_valid,
	output logic                           in_stall,
	input  logic [1:0]                     op,
	input  logic [31:0]                    byte_address,
	output logic                           out_valid,
	input  logic                           out_stall,
	output logic                           frame_used,
	output logic [fba_pkg::ADDR_OUT_W-1:0] free_address,
	output logic [1:0]                     status
);

	logic [fba_pkg::LIMIT_W-1:0] limit;
	fba_pkg::fba_cmd_t           cmd;
	fba_pkg::fba_sts_t           sts;

	fba_regs #(
		.BITMAP_WORDS(BITMAP_WORDS)
	) u_regs (
		.clk    (clk),
		.arst_n (arst_n),
		.psel   (psel),
		.penable(penable),
		.pwrite (pwrite),
		.paddr  (paddr),
		.pwdata (pwdata),
		.prdata (prdata),
		.pready (pready),
		.limit  (limit)
	);

	fba_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.op       (op),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.sts      (sts),
		.cmd      (cmd)
	);

	fba_dp #(
		.BITMAP_WORDS(BITMAP_WORDS),
		.FRAME_SHIFT (FRAME_SHIFT)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.sts         (sts),
		.limit       (limit),
		.op          (op),
		.byte_address(byte_address),
		.frame_used  (frame_used),
		.free_address(free_address),
		.status      (status)
	);

endmodule

[bench/tb_top.sv]
// Self-checking bench for frame_bitmap_allocator: APB setup of frame_count, random
// valid/stall traffic and an in-bench bitmap predictor compared result by result.
// Depends on fba_pkg and the frame_bitmap_allocator RTL only.
module tb_top;
	import fba_pkg::*;

	localparam int HOLD_CYCLES = 80;
	localparam int TAIL_CYCLES = BITMAP_WORDS_DEF + 80;

	typedef struct packed {
		logic                  frame_used;
		logic [ADDR_OUT_W-1:0] free_address;
		logic [1:0]            status;
	} alloc_result_t;

	logic                  clk;
	logic                  arst_n       = 1'b0;
	logic                  psel         = 1'b0;
	logic                  penable      = 1'b0;
	logic                  pwrite       = 1'b0;
	logic [PADDR_W-1:0]    paddr        = '0;
	logic [PDATA_W-1:0]    pwdata       = '0;
	logic [PDATA_W-1:0]    prdata;
	logic                  pready;
	logic                  in_valid     = 1'b0;
	logic                  in_stall;
	logic [1:0]            op           = OP_MARK;
	logic [31:0]           byte_address = '0;
	logic                  out_valid;
	logic                  out_stall    = 1'b0;
	logic                  frame_used;
	logic [ADDR_OUT_W-1:0] free_address;
	logic [1:0]            status;

	// predictor state
	logic [31:0]   frame_bits [BITMAP_WORDS_DEF] = '{default: '0};
	logic [15:0]   frame_count_q = '0;
	alloc_result_t alloc_results_due [$];
	alloc_result_t last_result;

	int send_idle_pct = 0;
	int stall_pct     = 0;
	int hold_gen      = 0;
	int hold_taken    = 0;
	int hold_left     = 0;
	int fail_count    = 0;
	int items_sent    = 0;
	int results_seen  = 0;
	int range_count   = 0;
	int none_count    = 0;
	int op_count [4]  = '{default: 0};

	frame_bitmap_allocator uut (
		.clk          (clk),
		.arst_n       (arst_n),
		.psel         (psel),
		.penable      (penable),
		.pwrite       (pwrite),
		.paddr        (paddr),
		.pwdata       (pwdata),
		.prdata       (prdata),
		.pready       (pready),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.op           (op),
		.byte_address (byte_address),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.frame_used   (frame_used),
		.free_address (free_address),
		.status       (status)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// generous cap: every item a worst-case scan plus long gaps and stalls
	initial begin
		#(8 * 3000000);
		$display("** frame_bitmap_allocator: FAILED **");
		$finish;
	end

	function automatic int words_in_use();
		int w;
		w = frame_count_q / WORD_BITS;
		if (w > BITMAP_WORDS_DEF)
			w = BITMAP_WORDS_DEF;
		return w;
	endfunction

	function automatic logic [31:0] frame_addr(input int unsigned frame);
		return (frame << FRAME_SHIFT_DEF) | $urandom_range(4095);
	endfunction

	function automatic alloc_result_t predict_alloc(input logic [1:0] o, input logic [31:0] a);
		alloc_result_t r;
		int unsigned   frame;
		int            word_idx;
		int            limit;
		int            i;
		int            j;
		logic [31:0]   bit_mask;
		logic          found;
		r = '0;
		frame = a >> FRAME_SHIFT_DEF;
		word_idx = frame / WORD_BITS;
		bit_mask = 32'd1 << (frame % WORD_BITS);
		limit = words_in_use();
		if (o == OP_FIND) begin
			found = 1'b0;
			for (i = 0; i < limit && !found; i++) begin
				if (frame_bits[i] != '1) begin
					for (j = 0; j < WORD_BITS && !found; j++) begin
						if (!frame_bits[i][j]) begin
							r.free_address = ADDR_OUT_W'((i * WORD_BITS + j) << FRAME_SHIFT_DEF);
							found = 1'b1;
						end
					end
				end
			end
			if (!found)
				r.status = ST_NONE;
		end else if (word_idx >= limit) begin
			r.status = ST_RANGE;
		end else begin
			case (o)
				OP_MARK: frame_bits[word_idx] |= bit_mask;
				OP_RELEASE: frame_bits[word_idx] &= ~bit_mask;
				default: r.frame_used = |(frame_bits[word_idx] & bit_mask);
			endcase
		end
		return r;
	endfunction

	// receiver: random stall, or a long hold-off when one is requested
	always @(posedge clk) begin
		if (hold_left > 0) begin
			out_stall <= 1'b1;
			hold_left <= hold_left - 1;
		end else if (hold_taken != hold_gen) begin
			hold_taken <= hold_gen;
			hold_left <= HOLD_CYCLES - 1;
			out_stall <= 1'b1;
		end else begin
			out_stall <= ($urandom_range(99) < stall_pct);
		end
	end

	always @(posedge clk) begin : result_check
		alloc_result_t want;
		if (arst_n && out_valid === 1'b1 && !out_stall) begin
			if (alloc_results_due.size() == 0) begin
				$error("result transfer with nothing expected");
				fail_count++;
			end else begin
				want = alloc_results_due.pop_front();
				results_seen++;
				if (frame_used !== want.frame_used) begin
					$error("frame_used: expected %0d, got %0d", want.frame_used, frame_used);
					fail_count++;
				end
				if (free_address !== want.free_address) begin
					$error("free_address: expected 0x%0h, got 0x%0h",
						want.free_address, free_address);
					fail_count++;
				end
				if (status !== want.status) begin
					$error("status: expected %0d, got %0d", want.status, status);
					fail_count++;
				end
			end
		end
	end

	task automatic send_item(input logic [1:0] o, input logic [31:0] a);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		op <= o;
		byte_address <= a;
		@(posedge clk);
		while (in_stall !== 1'b0)
			@(posedge clk);
		last_result = predict_alloc(o, a);
		alloc_results_due.push_back(last_result);
		items_sent++;
		op_count[o]++;
		if (last_result.status == ST_RANGE)
			range_count++;
		if (last_result.status == ST_NONE)
			none_count++;
	endtask

	task automatic wait_drained();
		in_valid <= 1'b0;
		@(posedge clk);
		while (alloc_results_due.size() != 0)
			@(posedge clk);
	endtask

	task automatic apb_access(input logic wr, input logic [31:0] wdata, output logic [31:0] rdata);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= wr;
		paddr <= {REG_FRAME_COUNT, 2'b00};
		pwdata <= wdata;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (pready !== 1'b1)
			@(posedge clk);
		rdata = prdata;
		psel <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
	endtask

	task automatic set_frame_count(input logic [15:0] value);
		logic [31:0] rdata;
		wait_drained();
		// upper bits are junk, the register keeps 16
		apb_access(1'b1, {16'($urandom()), value}, rdata);
		frame_count_q = value;
		apb_access(1'b0, '0, rdata);
		if (rdata !== {16'd0, value}) begin
			$error("frame_count: expected 0x%0h, got 0x%0h", value, rdata);
			fail_count++;
		end
	endtask

	task automatic set_idling(input int send_pct, input int recv_pct);
		send_idle_pct = send_pct;
		stall_pct = recv_pct;
	endtask

	task automatic test_no_words();
		set_frame_count(16'd0);
		send_item(OP_FIND, 32'h0);
		send_item(OP_MARK, 32'h0);
		send_item(OP_RELEASE, 32'h0);
		send_item(OP_TEST, 32'h0);
		// 31 frames is less than one whole word
		set_frame_count(16'd31);
		send_item(OP_FIND, 32'hFFFF_FFFF);
		send_item(OP_TEST, 32'h0001_F000);
	endtask

	task automatic test_single_word();
		set_frame_count(16'd32);
		send_item(OP_FIND, 32'hFFFF_FFFF);
		send_item(OP_MARK, 32'h0000_0000);
		send_item(OP_TEST, 32'h0000_0FFF);
		send_item(OP_TEST, 32'h0000_1000);
		send_item(OP_FIND, 32'h0);
		send_item(OP_MARK, 32'h0001_F123);
		send_item(OP_TEST, 32'h0001_F000);
		send_item(OP_RELEASE, 32'h0000_0ABC);
		send_item(OP_FIND, 32'h0);
		send_item(OP_RELEASE, 32'h0000_0000);
		send_item(OP_TEST, 32'h0002_0000);
		send_item(OP_MARK, 32'hFFFF_FFFF);
		send_item(OP_RELEASE, 32'hFFFF_F000);
	endtask

	task automatic test_full_words();
		int f;
		// 100 frames: three whole words, the last four frames unused
		set_frame_count(16'd100);
		for (f = 0; f < 96; f++)
			send_item(OP_MARK, frame_addr(f));
		send_item(OP_FIND, $urandom());
		send_item(OP_TEST, frame_addr(96));
		send_item(OP_RELEASE, frame_addr(70));
		send_item(OP_FIND, $urandom());
		send_item(OP_MARK, {5'd0, last_result.free_address});
		send_item(OP_FIND, $urandom());
	endtask

	task automatic test_address_extremes();
		// words in use cap at the bitmap size
		set_frame_count(16'hFFFF);
		send_item(OP_FIND, 32'h0);
		send_item(OP_MARK, 32'h07FF_F000);
		send_item(OP_TEST, 32'h07FF_FFFF);
		send_item(OP_MARK, 32'h0800_0000);
		set_frame_count(16'd32768);
		send_item(OP_RELEASE, 32'h07FF_FABC);
		send_item(OP_TEST, 32'h07FF_F000);
	endtask

	task automatic test_long_stall();
		int saved_idle;
		int k;
		set_frame_count(16'd96);
		saved_idle = send_idle_pct;
		send_idle_pct = 0;
		hold_gen++;
		// keep offering while the receiver holds off, so the input backs up
		for (k = 0; k < 24; k++)
			send_item(2'($urandom_range(3)), frame_addr($urandom_range(100)));
		wait_drained();
		send_idle_pct = saved_idle;
	endtask

	task automatic run_random_traffic(input int n_items);
		int span;
		int kind;
		int i;
		span = words_in_use() * WORD_BITS + 8;
		i = 0;
		while (i < n_items) begin
			kind = $urandom_range(99);
			if (kind < 40) begin
				// allocate: find, then usually mark what was found
				send_item(OP_FIND, $urandom());
				i++;
				if (last_result.status == ST_OK && $urandom_range(9) < 8) begin
					send_item(OP_MARK, {5'd0, last_result.free_address} | $urandom_range(4095));
					i++;
				end
			end else if (kind < 55) begin
				send_item(OP_MARK, frame_addr($urandom_range(span - 1)));
				i++;
			end else if (kind < 72) begin
				send_item(OP_RELEASE, frame_addr($urandom_range(span - 1)));
				i++;
			end else if (kind < 90) begin
				send_item(OP_TEST, frame_addr($urandom_range(span - 1)));
				i++;
			end else begin
				send_item(2'($urandom_range(3)), $urandom());
				i++;
			end
		end
	endtask

	task automatic test_random_mix(input logic [15:0] small_count, input logic [15:0] big_count);
		set_frame_count(small_count);
		run_random_traffic(70);
		set_frame_count(big_count);
		run_random_traffic(30);
	endtask

	initial begin
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		set_idling(13, 57);
		test_no_words();
		test_single_word();
		test_full_words();
		test_address_extremes();
		test_long_stall();
		test_random_mix(16'd100, 16'd1000);

		set_idling(57, 13);
		test_random_mix(16'd320, 16'd50000);

		set_idling(0, 0);
		test_random_mix(16'($urandom_range(400, 32)), 16'd32768);

		wait_drained();
		repeat (TAIL_CYCLES) @(posedge clk);
		$display("Checked %0d results of %0d transfers: %0d mark, %0d release, %0d test, %0d find.",
			results_seen, items_sent, op_count[OP_MARK], op_count[OP_RELEASE],
			op_count[OP_TEST], op_count[OP_FIND]);
		$display("%0d out-of-range and %0d bitmap-full results, frame_count from 0 to 65535.",
			range_count, none_count);
		if (fail_count == 0)
			$display("** frame_bitmap_allocator: PASSED **");
		else
			$display("** frame_bitmap_allocator: FAILED **");
		$finish;
	end

endmodule
